[rtl/uuid_tp_pkg.sv]
// Shared constants and decode functions for the UUID text parser.
`default_nettype none
package uuid_tp_pkg;

    localparam logic [7:0] CHAR_LBRACE = 8'h7B;
    localparam logic [7:0] CHAR_DASH   = 8'h2D;
    localparam logic [7:0] CHAR_RBRACE = 8'h7D;

    localparam logic [5:0] POS_LIMIT  = 6'd39;
    localparam logic [5:0] BRACED_LEN = 6'd38;
    localparam logic [5:0] PLAIN_LEN  = 6'd32;
    localparam logic [5:0] NO_SLOT    = 6'd32;

    localparam int NIBBLES = 32;

    typedef logic [3:0] t_nibble;

    typedef struct packed {
        logic    bad;
        t_nibble value;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.bad   = 1'b0;
        h.value = 4'd0;
        priority if (c >= 8'h30 && c <= 8'h39) begin
            h.value = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.value = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.value = 4'(c - 8'h37);
        end else begin
            h.bad = 1'b1;
        end
        return h;
    endfunction

    // Nibble slot of a hex position in the braced form, NO_SLOT for none.
    function automatic logic [5:0] braced_slot(input logic [5:0] p);
        logic [5:0] s;
        s = NO_SLOT;
        priority if (p >= 6'd1 && p <= 6'd8) begin
            s = p - 6'd1;
        end else if (p >= 6'd10 && p <= 6'd13) begin
            s = p - 6'd2;
        end else if (p >= 6'd15 && p <= 6'd18) begin
            s = p - 6'd3;
        end else if (p >= 6'd20 && p <= 6'd23) begin
            s = p - 6'd4;
        end else if (p >= 6'd25 && p <= 6'd36) begin
            s = p - 6'd5;
        end else begin
            s = NO_SLOT;
        end
        return s;
    endfunction

endpackage
`default_nettype wire

[rtl/uuid_text_parser.sv]
// Top level: UUID text parser, one character per transaction.
// Path: a final character passes the input register, then the result register.
// Throughput: one character per cycle; the position counter and nibble
// slot are written as each char advances. Output stalls hold only final chars.
// Reset (i_rst_n low, synchronous) clears position, form and error state.
`default_nettype none
module uuid_text_parser (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [7:0] text_char
    input  wire logic         s_axis_tlast,   // last_char
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [127:0]      m_axis_tdata,   // [63:0] uuid_high, [127:64] uuid_low
    output logic              m_axis_tuser    // [0] uuid_ok
);

    // input register
    logic        r_s1_valid;
    logic [7:0]  r_s1_char;
    logic        r_s1_last;

    // parse state
    logic [5:0]  r_pos;
    logic        r_braced;
    logic        r_err;
    uuid_tp_pkg::t_nibble r_nib [uuid_tp_pkg::NIBBLES];

    // result register
    logic         r_out_valid;
    logic [127:0] r_out_data;
    logic         r_out_ok;

    logic        adv;
    logic        in_take;
    logic        braced;
    logic        err;
    logic [5:0]  slot;
    uuid_tp_pkg::t_hex hex;
    logic        wr_nib;
    logic        len_ok;
    logic        ok;
    logic [63:0] n_hi;
    logic [63:0] n_lo;

    // Non-final characters give no result, so only final ones wait on the output.
    assign adv     = r_s1_valid && (!r_s1_last || !r_out_valid || m_axis_tready);
    assign in_take = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !r_s1_valid || adv;

    always_comb begin
        braced = (r_pos == 6'd0) ? (r_s1_char == uuid_tp_pkg::CHAR_LBRACE) : r_braced;
        err    = r_err;
        slot   = uuid_tp_pkg::NO_SLOT;
        hex    = uuid_tp_pkg::hex_decode(r_s1_char);
        if (braced) begin
            priority if (r_pos == 6'd0) begin
                slot = uuid_tp_pkg::NO_SLOT;
            end else if (r_pos == 6'd9 || r_pos == 6'd14 || r_pos == 6'd19
                         || r_pos == 6'd24) begin
                if (r_s1_char != uuid_tp_pkg::CHAR_DASH) err = 1'b1;
            end else if (r_pos == uuid_tp_pkg::BRACED_LEN - 6'd1) begin
                if (r_s1_char != uuid_tp_pkg::CHAR_RBRACE) err = 1'b1;
            end else if (r_pos >= uuid_tp_pkg::BRACED_LEN) begin
                err = 1'b1;
            end else begin
                slot = uuid_tp_pkg::braced_slot(r_pos);
            end
        end else begin
            if (r_pos >= uuid_tp_pkg::PLAIN_LEN) err = 1'b1;
            else slot = r_pos;
        end
        wr_nib = 1'b0;
        if (slot != uuid_tp_pkg::NO_SLOT) begin
            if (hex.bad) err = 1'b1;
            else wr_nib = 1'b1;
        end
        len_ok = braced ? (r_pos == uuid_tp_pkg::BRACED_LEN - 6'd1)
                        : (r_pos == uuid_tp_pkg::PLAIN_LEN - 6'd1);
        ok = len_ok && !err;
        // the current character's nibble takes part in its own result
        for (int i = 0; i < 16; i++) begin
            n_hi[63 - 4*i -: 4] = (wr_nib && slot[4:0] == 5'(i)) ? hex.value : r_nib[i];
            n_lo[63 - 4*i -: 4] = (wr_nib && slot[4:0] == 5'(i + 16))
                                  ? hex.value : r_nib[i + 16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_char <= s_axis_tdata;
            r_s1_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= 6'd0;
            r_braced <= 1'b0;
            r_err    <= 1'b0;
        end else if (adv) begin
            if (r_s1_last) begin
                r_pos    <= 6'd0;
                r_braced <= 1'b0;
                r_err    <= 1'b0;
            end else begin
                r_pos    <= (r_pos < uuid_tp_pkg::POS_LIMIT) ? r_pos + 6'd1
                                                             : uuid_tp_pkg::POS_LIMIT;
                r_braced <= braced;
                r_err    <= err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && wr_nib) begin
            r_nib[slot[4:0]] <= hex.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s1_last) begin
            r_out_data <= ok ? {n_lo, n_hi} : 128'd0;
            r_out_ok   <= ok;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_ok;

`ifndef NO_ASSERTIONS
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= uuid_tp_pkg::POS_LIMIT)
        else $error("position counter past its limit");

    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_ok) |-> (r_out_data == 128'd0))
        else $error("invalid result carries nonzero value");

    a_pos_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_s1_last) |=> (r_pos == 6'd0 && !r_err && !r_braced))
        else $error("parse state not cleared after final character");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !(adv && r_s1_last))
        else $error("result overwritten while stalled");
`endif

endmodule
`default_nettype wire
